// File: rtl/core/inverted_page_table_defines.svh
// assertion macros shared by the inverted page table rtl
`ifndef INVERTED_PAGE_TABLE_DEFINES_SVH
`define INVERTED_PAGE_TABLE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define IPT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define IPT_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IPT_ASSERT(lbl, prop, msg)
`define IPT_ASSERT_RST(lbl, prop, msg)
`endif

`endif

// File: rtl/core/ipt_pkg.sv
// types and codes shared by the inverted page table modules
package ipt_pkg;

    localparam logic [1:0] REQ_ALLOC  = 2'd0;
    localparam logic [1:0] REQ_FREE   = 2'd1;
    localparam logic [1:0] REQ_LOOKUP = 2'd2;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_PID   = 3'd1,
        ST_BAD_COUNT = 3'd2,
        ST_TOO_FEW   = 3'd3,
        ST_RANGE     = 3'd4,
        ST_NOT_FOUND = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        PASS_COUNT,
        PASS_ASSIGN,
        PASS_FREE,
        PASS_LOOKUP
    } pass_op_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PASS,
        S_HOLD
    } ctrl_state_t;

    // control part of the token that walks down the cell chain
    typedef struct packed {
        logic     valid;
        pass_op_t op;
        logic     found;
    } ipt_tok_t;

endpackage

// File: rtl/core/ipt_req_if.sv
// request channel: valid/ready plus the request fields
interface ipt_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [15:0] proc_id;
    logic [15:0] page_count;
    logic [15:0] page_number;

    modport source (output valid, req_type, proc_id, page_count, page_number, input ready);
    modport sink (input valid, req_type, proc_id, page_count, page_number, output ready);
endinterface

// File: rtl/core/ipt_rsp_if.sv
// response channel: valid/ready plus the result fields
interface ipt_rsp_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [7:0] frame_index;

    modport source (output valid, status, frame_index, input ready);
    modport sink (input valid, status, frame_index, output ready);
endinterface

// File: rtl/core/ipt_cell.sv
// one frame of the table: owner and page, plus one stage of the token chain
module ipt_cell
    import ipt_pkg::*;
#(
    parameter int NUM_FRAMES = 256,
    parameter int PID_BITS   = 16,
    parameter int IDX        = 0
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [PID_BITS-1:0]                 pid,
    input  logic [$clog2(NUM_FRAMES)-1:0]       key,
    input  ipt_tok_t                            tok_in,
    input  logic [$clog2(NUM_FRAMES+1)-1:0]     acc_in,
    output ipt_tok_t                            tok_out,
    output logic [$clog2(NUM_FRAMES+1)-1:0]     acc_out
);

    localparam int PW = $clog2(NUM_FRAMES);
    localparam int AW = $clog2(NUM_FRAMES + 1);

    logic [PID_BITS-1:0] owner_reg, owner_next;
    logic [PW-1:0]       page_reg, page_next;
    ipt_tok_t            tok_reg, tok_next;
    logic [AW-1:0]       acc_reg, acc_next;
    logic [AW-1:0]       acc_dec;
    logic                is_free;
    logic                is_mine;

    assign acc_dec = acc_in - AW'(1);
    assign is_free = (owner_reg == '0);
    assign is_mine = (owner_reg == pid);

    always_comb
    begin
        owner_next = owner_reg;
        page_next  = page_reg;
        tok_next   = tok_in;
        acc_next   = acc_in;
        if (tok_in.valid)
        begin
            unique case (tok_in.op)
                PASS_COUNT:
                begin
                    if (is_free)
                    begin
                        acc_next = acc_in + AW'(1);
                    end
                end
                PASS_ASSIGN:
                begin
                    // acc holds pages still to hand out, lowest frame gets the highest page
                    if (is_free && (acc_in != '0))
                    begin
                        owner_next = pid;
                        page_next  = acc_dec[PW-1:0];
                        acc_next   = acc_dec;
                    end
                end
                PASS_FREE:
                begin
                    if (is_mine)
                    begin
                        owner_next = '0;
                        page_next  = '0;
                    end
                end
                PASS_LOOKUP:
                begin
                    // first hit wins, later cells pass it through
                    if (!tok_in.found && is_mine && (page_reg == key))
                    begin
                        tok_next.found = 1'b1;
                        acc_next       = AW'(IDX);
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owner_reg <= '0;
            tok_reg   <= '0;
        end
        else
        begin
            owner_reg <= owner_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        page_reg <= page_next;
        acc_reg  <= acc_next;
    end

    assign tok_out = tok_reg;
    assign acc_out = acc_reg;

endmodule

// File: rtl/core/ipt_ctrl.sv
// request decode, pass sequencing and response register
`include "inverted_page_table_defines.svh"

module ipt_ctrl
    import ipt_pkg::*;
#(
    parameter int NUM_FRAMES = 256,
    parameter int PID_BITS   = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    ipt_req_if.sink                             req,
    ipt_rsp_if.source                           rsp,
    output logic [PID_BITS-1:0]                 pid,
    output logic [$clog2(NUM_FRAMES)-1:0]       key,
    output ipt_tok_t                            tok_out,
    output logic [$clog2(NUM_FRAMES+1)-1:0]     acc_out,
    input  ipt_tok_t                            tail,
    input  logic [$clog2(NUM_FRAMES+1)-1:0]     tail_acc
);

    localparam int PW = $clog2(NUM_FRAMES);
    localparam int AW = $clog2(NUM_FRAMES + 1);

    ctrl_state_t         state_reg, state_next;
    ipt_tok_t            tok_reg, tok_next;
    logic [AW-1:0]       acc_reg, acc_next;
    logic [PID_BITS-1:0] pid_reg, pid_next;
    logic [PW-1:0]       key_reg, key_next;
    logic [15:0]         count_reg, count_next;
    status_t             pend_status_reg, pend_status_next;
    logic [7:0]          pend_frame_reg, pend_frame_next;
    logic                out_valid_reg, out_valid_next;
    status_t             out_status_reg, out_status_next;
    logic [7:0]          out_frame_reg, out_frame_next;

    logic [PID_BITS+15:0] pid_wide;
    logic [PID_BITS-1:0]  pid_in;
    logic [AW+7:0]        tail_wide;
    logic                 req_launch;
    pass_op_t             req_op;
    status_t              req_status;
    logic                 enough;
    logic                 out_free;

    // pid is proc_id taken modulo 2^PID_BITS
    assign pid_wide  = {{PID_BITS{1'b0}}, req.proc_id};
    assign pid_in    = pid_wide[PID_BITS-1:0];
    assign tail_wide = {8'd0, tail_acc};
    assign enough    = (32'(tail_acc) >= 32'(count_reg));
    assign out_free  = !out_valid_reg || rsp.ready;

    // request checks in the order pid, count or range, then launch a pass
    always_comb
    begin
        req_launch = 1'b0;
        req_op     = PASS_COUNT;
        req_status = ST_OK;
        unique case (req.req_type)
            REQ_ALLOC:
            begin
                if (pid_in == '0)
                begin
                    req_status = ST_BAD_PID;
                end
                else if (req.page_count == 16'd0)
                begin
                    req_status = ST_BAD_COUNT;
                end
                else
                begin
                    req_launch = 1'b1;
                    req_op     = PASS_COUNT;
                end
            end
            REQ_FREE:
            begin
                if (pid_in == '0)
                begin
                    req_status = ST_BAD_PID;
                end
                else
                begin
                    req_launch = 1'b1;
                    req_op     = PASS_FREE;
                end
            end
            REQ_LOOKUP:
            begin
                if (pid_in == '0)
                begin
                    req_status = ST_BAD_PID;
                end
                else if (32'(req.page_number) >= 32'(NUM_FRAMES))
                begin
                    req_status = ST_RANGE;
                end
                else
                begin
                    req_launch = 1'b1;
                    req_op     = PASS_LOOKUP;
                end
            end
            default:
            begin
                req_status = ST_OK;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = req_launch ? S_PASS : S_HOLD;
                end
            end
            S_PASS:
            begin
                if (tail.valid)
                begin
                    if ((tail.op == PASS_COUNT) && enough)
                    begin
                        state_next = S_PASS;
                    end
                    else
                    begin
                        state_next = S_HOLD;
                    end
                end
            end
            S_HOLD:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        tok_next         = '0;
        acc_next         = acc_reg;
        pid_next         = pid_reg;
        key_next         = key_reg;
        count_next       = count_reg;
        pend_status_next = pend_status_reg;
        pend_frame_next  = pend_frame_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        out_status_next  = out_status_reg;
        out_frame_next   = out_frame_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    pid_next   = pid_in;
                    key_next   = req.page_number[PW-1:0];
                    count_next = req.page_count;
                    if (req_launch)
                    begin
                        tok_next.valid = 1'b1;
                        tok_next.op    = req_op;
                        acc_next       = '0;
                    end
                    else
                    begin
                        pend_status_next = req_status;
                        pend_frame_next  = 8'd0;
                    end
                end
            end
            S_PASS:
            begin
                if (tail.valid)
                begin
                    pend_status_next = ST_OK;
                    pend_frame_next  = 8'd0;
                    unique case (tail.op)
                        PASS_COUNT:
                        begin
                            if (enough)
                            begin
                                // second sweep hands out count frames
                                tok_next.valid = 1'b1;
                                tok_next.op    = PASS_ASSIGN;
                                acc_next       = AW'(count_reg);
                            end
                            else
                            begin
                                pend_status_next = ST_TOO_FEW;
                            end
                        end
                        PASS_LOOKUP:
                        begin
                            if (tail.found)
                            begin
                                pend_frame_next = tail_wide[7:0];
                            end
                            else
                            begin
                                pend_status_next = ST_NOT_FOUND;
                            end
                        end
                        PASS_ASSIGN, PASS_FREE:
                        begin
                            pend_status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_HOLD:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = pend_status_reg;
                    out_frame_next  = pend_frame_reg;
                end
            end
            default:
            begin
                tok_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tok_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tok_reg       <= tok_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg         <= acc_next;
        pid_reg         <= pid_next;
        key_reg         <= key_next;
        count_reg       <= count_next;
        pend_status_reg <= pend_status_next;
        pend_frame_reg  <= pend_frame_next;
        out_status_reg  <= out_status_next;
        out_frame_reg   <= out_frame_next;
    end

    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.frame_index = out_frame_reg;
    assign pid             = pid_reg;
    assign key             = key_reg;
    assign tok_out         = tok_reg;
    assign acc_out         = acc_reg;

    `IPT_ASSERT(a_tail_in_pass, tail.valid |-> (state_reg == S_PASS), "token left chain outside a pass")
    `IPT_ASSERT_RST(a_idle_no_token, req.ready |-> !tok_reg.valid, "token launched while idle")
    `IPT_ASSERT(a_out_from_hold, $rose(out_valid_reg) |-> $past(state_reg == S_HOLD), "response loaded outside hold")
    `IPT_ASSERT(a_count_bound, (tail.valid && (tail.op == PASS_COUNT)) |-> (32'(tail_acc) <= 32'(NUM_FRAMES)), "free count exceeds frame count")

endmodule

// File: rtl/core/inverted_page_table.sv
// inverted page table: request in, one response out per request
//
// req channel carries req_type (allocate, free, look up), proc_id, page_count
// and page_number; rsp channel returns status and frame_index, one beat per
// request beat, in order. Both use valid/ready; a beat moves when both are high.
// The table is a chain of NUM_FRAMES cells, one per frame. Every request that
// passes its checks walks a token down the chain, one cell per cycle, so the
// chain length sets the rate. Failed checks and unused req_type codes skip
// the chain. Free and lookup take one sweep; allocate takes one counting sweep
// and, when enough frames are free, one assigning sweep.
// One request is in work at a time; req.ready is high only between requests.
// Reset clears every owner, so all frames start free and the block takes a
// request right after reset is released.
// A stalled rsp holds its beat; the next result waits inside the block, and
// the next request is taken once that result has moved to the output register.
module inverted_page_table
    import ipt_pkg::*;
#(
    parameter int NUM_FRAMES = 256,
    parameter int PID_BITS   = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    ipt_req_if.sink    req,
    ipt_rsp_if.source  rsp
);

    localparam int PW = $clog2(NUM_FRAMES);
    localparam int AW = $clog2(NUM_FRAMES + 1);

    logic [PID_BITS-1:0] pid;
    logic [PW-1:0]       key;
    ipt_tok_t            tok   [NUM_FRAMES+1];
    logic [AW-1:0]       acc   [NUM_FRAMES+1];

    ipt_ctrl #(
        .NUM_FRAMES (NUM_FRAMES),
        .PID_BITS   (PID_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .rsp      (rsp),
        .pid      (pid),
        .key      (key),
        .tok_out  (tok[0]),
        .acc_out  (acc[0]),
        .tail     (tok[NUM_FRAMES]),
        .tail_acc (acc[NUM_FRAMES])
    );

    for (genvar i = 0; i < NUM_FRAMES; i++)
    begin : g_cell
        ipt_cell #(
            .NUM_FRAMES (NUM_FRAMES),
            .PID_BITS   (PID_BITS),
            .IDX        (i)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .pid     (pid),
            .key     (key),
            .tok_in  (tok[i]),
            .acc_in  (acc[i]),
            .tok_out (tok[i+1]),
            .acc_out (acc[i+1])
        );
    end

endmodule

// File: test/tb.sv
// testbench for the inverted page table: directed table then random requests
module tb;
    import ipt_pkg::*;

    localparam int TABLE_FRAMES = 256;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] pid;
        logic [15:0] count;
        logic [15:0] page;
    } ipt_request_t;

    typedef struct packed {
        status_t    status;
        logic [7:0] frame;
    } ipt_answer_t;

    typedef struct packed {
        ipt_request_t rq;
        logic         typed;
        ipt_answer_t  ans;
    } directed_row_t;

    logic clk;
    logic rst_n;

    ipt_req_if req ();
    ipt_rsp_if rsp ();

    inverted_page_table dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // shadow copy of the table
    logic [15:0] frame_owner [TABLE_FRAMES];
    logic [7:0]  frame_page  [TABLE_FRAMES];

    ipt_answer_t   answers_due [$];
    directed_row_t directed_rows [$];
    int            bad_beats = 0;
    int            requests_taken = 0;
    int            burst_left = 0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #40000000;
        $display("inverted_page_table verification failed");
        $finish;
    end

    function automatic ipt_answer_t page_table_access(input ipt_request_t rq);
        ipt_answer_t ans;
        int unsigned free_frames;
        int unsigned left;
        ans.status  = ST_OK;
        ans.frame   = 8'd0;
        free_frames = 0;
        case (rq.kind)
            REQ_ALLOC:
            begin
                if (rq.pid == 16'd0)
                    ans.status = ST_BAD_PID;
                else if (rq.count == 16'd0)
                    ans.status = ST_BAD_COUNT;
                else
                begin
                    foreach (frame_owner[f])
                        if (frame_owner[f] == 16'd0)
                            free_frames++;
                    if (free_frames < rq.count)
                        ans.status = ST_TOO_FEW;
                    else
                    begin
                        // lowest free frame gets the highest page
                        left = rq.count;
                        foreach (frame_owner[f])
                        begin
                            if (left != 0 && frame_owner[f] == 16'd0)
                            begin
                                left--;
                                frame_owner[f] = rq.pid;
                                frame_page[f]  = 8'(left);
                            end
                        end
                    end
                end
            end
            REQ_FREE:
            begin
                if (rq.pid == 16'd0)
                    ans.status = ST_BAD_PID;
                else
                begin
                    foreach (frame_owner[f])
                    begin
                        if (frame_owner[f] == rq.pid)
                        begin
                            frame_owner[f] = 16'd0;
                            frame_page[f]  = 8'd0;
                        end
                    end
                end
            end
            REQ_LOOKUP:
            begin
                if (rq.pid == 16'd0)
                    ans.status = ST_BAD_PID;
                else if (rq.page >= TABLE_FRAMES)
                    ans.status = ST_RANGE;
                else
                begin
                    ans.status = ST_NOT_FOUND;
                    // walk downward so the lowest match is the one kept
                    for (int f = TABLE_FRAMES - 1; f >= 0; f--)
                    begin
                        if (frame_owner[f] == rq.pid && {8'd0, frame_page[f]} == rq.page)
                        begin
                            ans.status = ST_OK;
                            ans.frame  = 8'(f);
                        end
                    end
                end
            end
            default: ;
        endcase
        return ans;
    endfunction

    task automatic add_row(input logic [1:0] kind, input logic [15:0] pid,
                           input logic [15:0] count, input logic [15:0] page,
                           input logic typed, input status_t status, input logic [7:0] frame);
        directed_row_t row;
        row.rq.kind    = kind;
        row.rq.pid     = pid;
        row.rq.count   = count;
        row.rq.page    = page;
        row.typed      = typed;
        row.ans.status = status;
        row.ans.frame  = frame;
        directed_rows.push_back(row);
    endtask

    // offers one request beat, pacing the sender in bursts with gaps between
    task automatic offer(input ipt_request_t rq, input logic typed, input ipt_answer_t typed_ans);
        ipt_answer_t predicted;
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap != 0)
            begin
                req.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        req.valid       <= 1'b1;
        req.req_type    <= rq.kind;
        req.proc_id     <= rq.pid;
        req.page_count  <= rq.count;
        req.page_number <= rq.page;
        do @(posedge clk); while (!req.ready);
        predicted = page_table_access(rq);
        answers_due.push_back(typed ? typed_ans : predicted);
        requests_taken++;
    endtask

    // response checker
    always @(posedge clk)
    begin : check_rsp
        ipt_answer_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (answers_due.size() == 0)
            begin
                if (bad_beats < 10)
                    $display("response beat with nothing outstanding: status %0d frame %0d",
                             rsp.status, rsp.frame_index);
                bad_beats++;
            end
            else
            begin
                want = answers_due.pop_front();
                if (rsp.status !== want.status || rsp.frame_index !== want.frame)
                begin
                    if (bad_beats < 10)
                        $display("beat mismatch: status %0d frame %0d, wanted status %0d frame %0d",
                                 rsp.status, rsp.frame_index, want.status, want.frame);
                    bad_beats++;
                end
            end
        end
    end

    // receiver stall pattern, with one long hold-off to back the block up
    initial
    begin : drive_ready
        int mode;
        int span;
        logic held;
        held = 1'b0;
        rsp.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!held && requests_taken >= 400)
            begin
                held = 1'b1;
                rsp.ready <= 1'b0;
                repeat (1500) @(posedge clk);
            end
            mode = $urandom_range(0, 2);
            span = $urandom_range(20, 200);
            repeat (span)
            begin
                case (mode)
                    0: rsp.ready <= 1'b1;
                    1: rsp.ready <= ($urandom_range(0, 3) != 0);
                    default: rsp.ready <= ($urandom_range(0, 15) == 0);
                endcase
                @(posedge clk);
            end
        end
    end

    initial
    begin : stimulus
        ipt_request_t rq;
        ipt_answer_t  none;
        logic [15:0]  pid_pool [12];
        int           roll;
        int           pick;

        none.status = ST_OK;
        none.frame  = 8'd0;
        foreach (frame_owner[f])
        begin
            frame_owner[f] = 16'd0;
            frame_page[f]  = 8'd0;
        end
        pid_pool[0] = 16'h0001;
        pid_pool[1] = 16'hFFFF;
        pid_pool[2] = 16'h8000;
        for (int i = 3; i < 12; i++)
            pid_pool[i] = 16'($urandom_range(1, 65535));

        rst_n           <= 1'b0;
        req.valid       <= 1'b0;
        req.req_type    <= REQ_ALLOC;
        req.proc_id     <= 16'd0;
        req.page_count  <= 16'd0;
        req.page_number <= 16'd0;

        add_row(REQ_LOOKUP, 16'h0001, 16'h0000, 16'h0000, 1'b1, ST_NOT_FOUND, 8'd0);
        add_row(REQ_ALLOC,  16'h0000, 16'h0005, 16'h0000, 1'b1, ST_BAD_PID,   8'd0);
        add_row(REQ_ALLOC,  16'h0007, 16'h0000, 16'hFFFF, 1'b1, ST_BAD_COUNT, 8'd0);
        add_row(REQ_ALLOC,  16'h0000, 16'h0000, 16'h0000, 1'b1, ST_BAD_PID,   8'd0);
        add_row(REQ_ALLOC,  16'h0003, 16'd257,  16'h0000, 1'b1, ST_TOO_FEW,   8'd0);
        add_row(REQ_ALLOC,  16'hFFFF, 16'hFFFF, 16'h0000, 1'b1, ST_TOO_FEW,   8'd0);
        add_row(REQ_ALLOC,  16'hFFFF, 16'd256,  16'h0000, 1'b1, ST_OK,        8'd0);
        add_row(REQ_ALLOC,  16'h0002, 16'h0001, 16'h0000, 1'b1, ST_TOO_FEW,   8'd0);
        add_row(REQ_LOOKUP, 16'hFFFF, 16'h0000, 16'd255,  1'b1, ST_OK,        8'd0);
        add_row(REQ_LOOKUP, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b1, ST_OK,        8'd255);
        add_row(REQ_LOOKUP, 16'hFFFF, 16'h0000, 16'd256,  1'b1, ST_RANGE,     8'd0);
        add_row(REQ_LOOKUP, 16'h0000, 16'h0000, 16'hFFFF, 1'b1, ST_BAD_PID,   8'd0);
        add_row(REQ_LOOKUP, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b1, ST_RANGE,     8'd0);
        add_row(REQ_FREE,   16'h0000, 16'hFFFF, 16'hFFFF, 1'b1, ST_BAD_PID,   8'd0);
        add_row(REQ_FREE,   16'hFFFF, 16'h0000, 16'h0000, 1'b1, ST_OK,        8'd0);
        add_row(REQ_FREE,   16'hFFFF, 16'h0000, 16'h0000, 1'b1, ST_OK,        8'd0);
        add_row(REQ_LOOKUP, 16'hFFFF, 16'h0000, 16'h0000, 1'b1, ST_NOT_FOUND, 8'd0);
        add_row(REQ_UNUSED, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b1, ST_OK,        8'd0);
        add_row(REQ_ALLOC,  16'h0001, 16'h0003, 16'h0000, 1'b0, ST_OK,        8'd0);
        add_row(REQ_ALLOC,  16'h0002, 16'h0002, 16'h0000, 1'b0, ST_OK,        8'd0);
        add_row(REQ_ALLOC,  16'h0001, 16'h0002, 16'h0000, 1'b0, ST_OK,        8'd0);
        add_row(REQ_LOOKUP, 16'h0001, 16'h0000, 16'h0001, 1'b0, ST_OK,        8'd0);
        add_row(REQ_LOOKUP, 16'h0001, 16'h0000, 16'h0000, 1'b0, ST_OK,        8'd0);
        add_row(REQ_FREE,   16'h0002, 16'h0000, 16'h0000, 1'b0, ST_OK,        8'd0);
        add_row(REQ_ALLOC,  16'h0009, 16'h0004, 16'h0000, 1'b0, ST_OK,        8'd0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            offer(directed_rows[i].rq, directed_rows[i].typed, directed_rows[i].ans);

        for (int n = 0; n < 1125; n++)
        begin
            if (n == 700)
            begin
                // let the block drain completely before going on
                req.valid <= 1'b0;
                do @(posedge clk); while (answers_due.size() != 0);
                burst_left = 0;
            end
            roll     = $urandom_range(0, 99);
            pick     = $urandom_range(0, 11);
            rq.pid   = ($urandom_range(0, 19) == 0) ? 16'd0 : pid_pool[pick];
            rq.count = 16'($urandom);
            rq.page  = 16'($urandom);
            if (roll < 28)
            begin
                rq.kind = REQ_ALLOC;
                case ($urandom_range(0, 9))
                    7: rq.count = 16'($urandom_range(13, 100));
                    8: rq.count = 16'($urandom_range(100, 300));
                    9: ;
                    default: rq.count = 16'($urandom_range(1, 12));
                endcase
                if ($urandom_range(0, 29) == 0)
                    rq.count = 16'd0;
            end
            else if (roll < 43)
                rq.kind = REQ_FREE;
            else if (roll < 90)
            begin
                rq.kind = REQ_LOOKUP;
                case ($urandom_range(0, 9))
                    8: rq.page = 16'($urandom_range(250, 260));
                    9: ;
                    default: rq.page = 16'($urandom_range(0, 15));
                endcase
            end
            else if (roll < 95)
                rq.kind = REQ_UNUSED;
            else
            begin
                rq.kind = 2'($urandom);
                rq.pid  = 16'($urandom);
            end
            offer(rq, 1'b0, none);
        end
        req.valid <= 1'b0;

        while (answers_due.size() != 0)
            @(posedge clk);
        repeat (600) @(posedge clk);
        if (bad_beats == 0)
            $display("inverted_page_table verification clean");
        else
            $display("inverted_page_table verification failed");
        $finish;
    end

endmodule
